// ----- rtl/gdr_pkg.sv -----
// Package with the shared types, constants and the saturating-add helper of the grid reducer.
package gdr_pkg;

	localparam int RedW = 32;
	localparam int RedIdxW = 5;
	localparam int SrcDim = 4096;
	localparam int DimW = 13;
	localparam int ValW = 48;
	localparam int SmpW = 32;
	localparam int CntW = 13;
	localparam int DivW = 64;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW = 2;

	localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
	localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};
	localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

	typedef enum logic [1:0] {
		OP_SAMPLE  = 2'd0,
		OP_RESTART = 2'd1,
		OP_NEWFRM  = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_AVG = 2'd0,
		MODE_SUM = 2'd1,
		MODE_MIN = 2'd2,
		MODE_MAX = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_SRC_W  = 3'd0,
		REG_SRC_H  = 3'd1,
		REG_RED_W  = 3'd2,
		REG_RED_H  = 3'd3,
		REG_MODE   = 3'd4
	} reg_idx_t;

	// Classified request passed from the front part to the back part.
	typedef struct packed {
		logic                   restart;
		logic                   clear_range;
		logic [RedIdxW-1:0]     col;
		logic signed [SmpW-1:0] smp;
		logic                   row_done;
		logic                   band_end;
		logic                   band_start;
		logic [11:0]            band;
	} req_t;

	function automatic logic signed [ValW-1:0] sat_add(
		input logic signed [ValW-1:0] a, input logic signed [ValW-1:0] b);
		logic signed [ValW:0] s;
		s = {a[ValW-1], a} + {b[ValW-1], b};
		if (s[ValW] != s[ValW-1]) begin
			return s[ValW] ? ValMin : ValMax;
		end
		return s[ValW-1:0];
	endfunction

endpackage

// ----- rtl/gdr_divider.sv -----
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
module gdr_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [gdr_pkg::ValW-1:0] dividend,
	input  logic [gdr_pkg::CntW-1:0]        divisor,
	output logic                            busy,
	output logic                            done,
	output logic signed [gdr_pkg::ValW-1:0] quotient
);
	import gdr_pkg::*;

	logic [ValW-1:0] mag_q;
	logic [ValW-1:0] quo_q;
	logic [CntW:0]   rem_q;
	logic [CntW-1:0] den_q;
	logic            neg_q;
	logic [5:0]      cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [CntW:0]   trial;
	logic [CntW:0]   shifted;

	assign shifted = {rem_q[CntW-1:0], mag_q[ValW-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(ValW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[ValW-1] ? ValW'(-dividend) : dividend;
			neg_q <= dividend[ValW-1];
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[ValW-2:0], 1'b0};
			if (!trial[CntW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[ValW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[ValW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = neg_q ? ValW'(-quo_q) : quo_q;
endmodule

// ----- rtl/gdr_front.sv -----
// Front part: register file, frame position tracking and request classification.
module gdr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [12:0]                 cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  opcode,
	input  logic signed [31:0]          sample,
	output logic                        req_valid,
	input  logic                        req_ready,
	output gdr_pkg::req_t               req,
	output logic [gdr_pkg::RedIdxW:0]   red_w,
	output gdr_pkg::mode_t              mode
);
	import gdr_pkg::*;

	typedef enum logic [2:0] {
		SY_IDLE,
		SY_COL_LOAD,
		SY_ROW_LOAD,
		SY_RUN,
		SY_STORE
	} sync_t;

	logic [DimW-1:0] src_w_q, src_h_q, red_h_q;
	logic [5:0]      red_w_q;
	mode_t           mode_q;
	logic [DimW-1:0] sw, sh, rh;
	logic [6:0]      rwc;
	logic [RedIdxW:0] rw;
	logic [DimW-1:0] col_q, row_q;
	logic [DimW-1:0] colacc_q;
	logic [RedIdxW:0] ri_q;
	logic [24:0]     rowacc_q;
	logic [DimW-1:0] ry_q;
	logic            band_open_q;
	logic            in_frame;
	logic            accept;
	logic            issue;
	logic            row_done;
	logic [24:0]     nxt_rowacc;
	logic [DimW-1:0] nxt_ry;
	logic            band_end;
	logic [RedIdxW:0] ri_clamp;
	logic [DimW-1:0] nxt_colacc;
	logic [RedIdxW:0] nxt_ri;
	sync_t           sync_q;
	logic            sync_row_q;
	logic [24:0]     dnum_q, dquo_q;
	logic [DimW-1:0] drem_q, dden_q;
	logic [4:0]      dstep_q;
	logic [DimW:0]   dshift, dtrial;

	always_comb begin
		sw = (src_w_q == '0) ? 13'd1 : (src_w_q > 13'(SrcDim) ? 13'(SrcDim) : src_w_q);
		sh = (src_h_q == '0) ? 13'd1 : (src_h_q > 13'(SrcDim) ? 13'(SrcDim) : src_h_q);
		rh = (red_h_q == '0) ? 13'd1 : (red_h_q > 13'(SrcDim) ? 13'(SrcDim) : red_h_q);
		rh = (rh > sh) ? sh : rh;
		rwc = (red_w_q == '0) ? 7'd1 : (red_w_q > 6'(RedW) ? 7'(RedW) : {1'b0, red_w_q});
		rw = (13'(rwc) > sw) ? (RedIdxW+1)'(sw) : (RedIdxW+1)'(rwc);
	end

	// Column index col*rw/sw kept incrementally: colacc holds col*rw mod sw.
	// After a register write both positions are rebuilt, each by a serial division.
	always_comb begin
		in_frame = row_q < sh;
		accept = push && !full;
		issue = accept && (opcode == OP_RESTART || opcode == OP_NEWFRM ||
			(opcode == OP_SAMPLE && in_frame));
		row_done = (col_q + 13'd1 >= sw);
		ri_clamp = (ri_q >= rw) ? rw - 1'b1 : ri_q;
		nxt_rowacc = rowacc_q + 25'(rh);
		nxt_ry = ry_q;
		if (nxt_rowacc >= 25'(sh)) begin
			nxt_ry = ry_q + 13'd1;
		end
		band_end = (row_q + 13'd1 >= sh) || (nxt_ry != ry_q);
		nxt_colacc = colacc_q + 13'(rw);
		nxt_ri = ri_q;
		if (nxt_colacc >= sw) begin
			nxt_colacc = nxt_colacc - sw;
			nxt_ri = ri_q + 1'b1;
		end
	end

	assign dshift = {drem_q, dnum_q[24]};
	assign dtrial = dshift - {1'b0, dden_q};

	assign full = (req_valid && !req_ready) || (sync_q != SY_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= 13'd1;
			src_h_q <= 13'd1;
			red_w_q <= 6'd32;
			red_h_q <= 13'd32;
			mode_q <= MODE_AVG;
			col_q <= '0;
			row_q <= '0;
			colacc_q <= '0;
			ri_q <= '0;
			rowacc_q <= '0;
			ry_q <= '0;
			band_open_q <= 1'b0;
			req_valid <= 1'b0;
			sync_q <= SY_IDLE;
			sync_row_q <= 1'b0;
			dnum_q <= '0;
			dquo_q <= '0;
			drem_q <= '0;
			dden_q <= '0;
			dstep_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_W: src_w_q <= cfg_data;
					REG_SRC_H: src_h_q <= cfg_data;
					REG_RED_W: red_w_q <= cfg_data[5:0];
					REG_RED_H: red_h_q <= cfg_data;
					REG_MODE:  mode_q <= mode_t'(cfg_data[1:0]);
					default: ;
				endcase
			end
			if (cfg_we) begin
				sync_q <= SY_COL_LOAD;
			end else begin
				unique case (sync_q)
					SY_IDLE: ;
					SY_COL_LOAD: begin
						dnum_q <= 25'(col_q) * 25'(rw);
						dden_q <= sw;
						drem_q <= '0;
						dquo_q <= '0;
						dstep_q <= 5'd25;
						sync_row_q <= 1'b0;
						sync_q <= SY_RUN;
					end
					SY_ROW_LOAD: begin
						dnum_q <= 25'(row_q) * 25'(rh);
						dden_q <= sh;
						drem_q <= '0;
						dquo_q <= '0;
						dstep_q <= 5'd25;
						sync_row_q <= 1'b1;
						sync_q <= SY_RUN;
					end
					SY_RUN: begin
						dnum_q <= {dnum_q[23:0], 1'b0};
						if (!dtrial[DimW]) begin
							drem_q <= dtrial[DimW-1:0];
							dquo_q <= {dquo_q[23:0], 1'b1};
						end else begin
							drem_q <= dshift[DimW-1:0];
							dquo_q <= {dquo_q[23:0], 1'b0};
						end
						dstep_q <= dstep_q - 5'd1;
						if (dstep_q == 5'd1) sync_q <= SY_STORE;
					end
					SY_STORE: begin
						if (!sync_row_q) begin
							ri_q <= (dquo_q >= 25'(rw)) ? rw : dquo_q[RedIdxW:0];
							colacc_q <= drem_q;
							sync_q <= SY_ROW_LOAD;
						end else begin
							ry_q <= dquo_q[DimW-1:0];
							rowacc_q <= 25'(drem_q);
							sync_q <= SY_IDLE;
						end
					end
					default: sync_q <= SY_IDLE;
				endcase
			end
			if (issue) begin
				req_valid <= 1'b1;
			end else if (req_ready) begin
				req_valid <= 1'b0;
			end
			if (accept) begin
				if (opcode == OP_RESTART || opcode == OP_NEWFRM) begin
					col_q <= '0;
					row_q <= '0;
					colacc_q <= '0;
					ri_q <= '0;
					rowacc_q <= '0;
					ry_q <= '0;
					band_open_q <= 1'b0;
				end else if (opcode == OP_SAMPLE && in_frame) begin
					if (row_done) begin
						col_q <= '0;
						colacc_q <= '0;
						ri_q <= '0;
						row_q <= row_q + 13'd1;
						rowacc_q <= (nxt_rowacc >= 25'(sh)) ? nxt_rowacc - 25'(sh) : nxt_rowacc;
						ry_q <= nxt_ry;
						band_open_q <= !band_end;
					end else begin
						col_q <= col_q + 13'd1;
						colacc_q <= nxt_colacc;
						ri_q <= nxt_ri;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req.restart <= (opcode == OP_RESTART || opcode == OP_NEWFRM);
			req.clear_range <= (opcode == OP_NEWFRM);
			req.col <= ri_clamp[RedIdxW-1:0];
			req.smp <= sample;
			req.row_done <= row_done;
			req.band_end <= band_end;
			req.band_start <= !band_open_q;
			req.band <= ry_q[11:0];
		end
	end

	assign red_w = rw;
	assign mode = mode_q;
endmodule

// ----- rtl/gdr_queue.sv -----
// Short request queue between the front and the back part.
module gdr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  gdr_pkg::req_t in_req,
	output logic          out_valid,
	input  logic          out_ready,
	output gdr_pkg::req_t out_req
);
	import gdr_pkg::*;

	req_t                 slot_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_q, rd_q;
	logic [QueuePtrW:0]   cnt_q;
	logic                 wr, rd;

	assign in_ready = cnt_q != (QueuePtrW+1)'(QueueDepth);
	assign out_valid = cnt_q != '0;
	assign out_req = slot_q[rd_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wr_q <= wr_q + 1'b1;
			if (rd) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QueuePtrW+1)'(wr) - (QueuePtrW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) slot_q[wr_q] <= in_req;
	end
endmodule

// ----- rtl/gdr_back.sv -----
// Back part: cell accumulation, row and band folding, and emission of reduced rows.
module gdr_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  gdr_pkg::req_t                   req,
	input  logic [gdr_pkg::RedIdxW:0]       red_w,
	input  gdr_pkg::mode_t                  mode,
	output logic                            empty,
	input  logic                            pop,
	output logic [4:0]                      cell_col,
	output logic [11:0]                     cell_row,
	output logic signed [47:0]              cell_value,
	output logic signed [47:0]              range_low,
	output logic signed [47:0]              range_high,
	output logic                            row_end
);
	import gdr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FOLD,
		ST_FOLD_WAIT,
		ST_EMIT,
		ST_EMIT_WAIT,
		ST_OUT
	} state_t;

	state_t                 state_q;
	logic signed [ValW-1:0] col_acc_q [RedW];
	logic [CntW-1:0]        col_cnt_q [RedW];
	logic signed [ValW-1:0] band_acc_q [RedW];
	logic [CntW-1:0]        band_rows_q;
	logic [11:0]            red_row_q;
	logic signed [ValW-1:0] seen_low_q, seen_high_q;
	logic [RedIdxW:0]       c_q;
	logic                   band_end_q;
	logic                   div_start;
	logic signed [ValW-1:0] div_a;
	logic [CntW-1:0]        div_b;
	logic                   div_busy, div_done;
	logic signed [ValW-1:0] div_q;
	logic signed [ValW-1:0] smp48;
	logic signed [ValW-1:0] cur;
	logic [CntW-1:0]        cur_cnt;
	logic [RedIdxW-1:0]     ci;
	logic                   out_full_q;
	logic                   out_load;
	logic signed [ValW-1:0] v;

	assign ci = c_q[RedIdxW-1:0];
	assign smp48 = ValW'(req.smp);
	assign cur = col_acc_q[req.col];
	assign cur_cnt = col_cnt_q[req.col];
	assign v = band_acc_q[ci];
	assign req_ready = (state_q == ST_IDLE) && !div_busy;
	assign empty = !out_full_q;
	assign out_load = (state_q == ST_EMIT && c_q != red_w && (!out_full_q || pop) &&
		band_rows_q <= 13'd1) || (state_q == ST_EMIT_WAIT && div_done);

	gdr_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .busy(div_busy), .done(div_done), .quotient(div_q)
	);

	always_comb begin
		div_start = 1'b0;
		div_a = col_acc_q[ci];
		div_b = col_cnt_q[ci];
		if (state_q == ST_FOLD && c_q != red_w && mode == MODE_AVG &&
			col_cnt_q[ci] > 13'd1) begin
			div_start = 1'b1;
		end
		if (state_q == ST_EMIT) begin
			div_a = band_acc_q[ci];
			div_b = band_rows_q;
			div_start = (c_q != red_w) && (band_rows_q > 13'd1) && !out_full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_full_q <= 1'b0;
			band_rows_q <= '0;
			seen_low_q <= ValMax;
			seen_high_q <= '0;
			c_q <= '0;
			band_end_q <= 1'b0;
			for (int i = 0; i < RedW; i++) begin
				col_acc_q[i] <= '0;
				col_cnt_q[i] <= '0;
				band_acc_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_full_q <= 1'b1;
			end else if (pop) begin
				out_full_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid && !div_busy) begin
						if (req.restart) begin
							band_rows_q <= '0;
							for (int i = 0; i < RedW; i++) begin
								col_acc_q[i] <= '0;
								col_cnt_q[i] <= '0;
								band_acc_q[i] <= '0;
							end
							if (req.clear_range) begin
								seen_low_q <= ValMax;
								seen_high_q <= '0;
							end
						end else begin
							case (mode)
								MODE_AVG, MODE_SUM: col_acc_q[req.col] <= sat_add(cur, smp48);
								MODE_MIN: if (cur_cnt == '0 || smp48 < cur) col_acc_q[req.col] <= smp48;
								default: if (cur_cnt == '0 || smp48 > cur) col_acc_q[req.col] <= smp48;
							endcase
							if (cur_cnt != CntMax) col_cnt_q[req.col] <= cur_cnt + 13'd1;
							if (req.row_done) begin
								if (req.band_start) begin
									red_row_q <= req.band;
									for (int i = 0; i < RedW; i++) band_acc_q[i] <= '0;
								end
								band_end_q <= req.band_end;
								c_q <= '0;
								state_q <= ST_FOLD;
							end
						end
					end
				end
				ST_FOLD: begin
					if (c_q == red_w) begin
						if (band_rows_q != CntMax) band_rows_q <= band_rows_q + 13'd1;
						for (int i = 0; i < RedW; i++) begin
							col_acc_q[i] <= '0;
							col_cnt_q[i] <= '0;
						end
						c_q <= '0;
						state_q <= band_end_q ? ST_EMIT : ST_IDLE;
					end else if (div_start) begin
						state_q <= ST_FOLD_WAIT;
					end else begin
						band_acc_q[ci] <= sat_add(band_acc_q[ci], col_acc_q[ci]);
						c_q <= c_q + 1'b1;
					end
				end
				ST_FOLD_WAIT: begin
					if (div_done) begin
						band_acc_q[ci] <= sat_add(band_acc_q[ci], div_q);
						c_q <= c_q + 1'b1;
						state_q <= ST_FOLD;
					end
				end
				ST_EMIT: begin
					if (c_q == red_w) begin
						band_rows_q <= '0;
						state_q <= ST_IDLE;
					end else if (!out_full_q || pop) begin
						if (band_rows_q > 13'd1) begin
							if (!out_full_q) state_q <= ST_EMIT_WAIT;
						end else begin
							cell_value <= v;
							cell_col <= ci;
							cell_row <= red_row_q;
							row_end <= (c_q + 1'b1 == red_w);
							range_low <= (v < seen_low_q) ? v : seen_low_q;
							range_high <= (v > seen_high_q) ? v : seen_high_q;
							if (v < seen_low_q) seen_low_q <= v;
							if (v > seen_high_q) seen_high_q <= v;
							c_q <= c_q + 1'b1;
						end
					end
				end
				ST_EMIT_WAIT: begin
					if (div_done) begin
						cell_value <= div_q;
						cell_col <= ci;
						cell_row <= red_row_q;
						row_end <= (c_q + 1'b1 == red_w);
						range_low <= (div_q < seen_low_q) ? div_q : seen_low_q;
						range_high <= (div_q > seen_high_q) ? div_q : seen_high_q;
						if (div_q < seen_low_q) seen_low_q <= div_q;
						if (div_q > seen_high_q) seen_high_q <= div_q;
						c_q <= c_q + 1'b1;
						state_q <= ST_EMIT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/grid_downsample_reducer_unit.sv -----
// Top level of the grid downsample reducer.
// The block shrinks a raster-order grid of signed Q16.16 samples to at most
// 32 reduced columns by a configured number of reduced rows.
// Requests enter through push and full with an opcode and a sample: sample,
// restart keeping the range, new frame clearing the range, or none.
// Results leave through empty and pop, one reduced cell at a time, with its
// column, row, value, the running range and a flag on the last cell of a row.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle;
// after each write the front part holds full while it rebuilds its column and row positions.
// The back part takes a sample inside a row without leaving its idle state; the front
// part takes one request per cycle, while full is low, into a four-entry queue.
// At the end of each source row the back part walks the reduced columns, and in
// average mode each column with more than one sample goes through the 48-step
// serial divider; emitting a band passes each cell through the divider, in every
// mode, when the band holds more than one row.
// When the receiver stalls, the back part holds the cell and stops; the queue
// then fills and full rises.
// Reset clears the positions, accumulators and the range, and loads the
// register reset values.
module grid_downsample_reducer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] sample,
	output logic               empty,
	input  logic               pop,
	output logic [4:0]         cell_col,
	output logic [11:0]        cell_row,
	output logic signed [47:0] cell_value,
	output logic signed [47:0] range_low,
	output logic signed [47:0] range_high,
	output logic               row_end
);
	import gdr_pkg::*;

	logic             f_valid, f_ready;
	req_t             f_req;
	logic             b_valid, b_ready;
	req_t             b_req;
	logic [RedIdxW:0] red_w;
	mode_t            mode;

	gdr_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .push(push), .full(full), .opcode(opcode),
		.sample(sample), .req_valid(f_valid), .req_ready(f_ready), .req(f_req),
		.red_w(red_w), .mode(mode)
	);

	gdr_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .in_ready(f_ready),
		.in_req(f_req), .out_valid(b_valid), .out_ready(b_ready), .out_req(b_req)
	);

	gdr_back u_back (
		.clk(clk), .arst_n(arst_n), .req_valid(b_valid), .req_ready(b_ready),
		.req(b_req), .red_w(red_w), .mode(mode), .empty(empty), .pop(pop),
		.cell_col(cell_col), .cell_row(cell_row), .cell_value(cell_value),
		.range_low(range_low), .range_high(range_high), .row_end(row_end)
	);
endmodule

// ----- rtl/gdr_checker.sv -----
// Port-level checker for the grid downsample reducer, bound to the top level.
module gdr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [4:0]         cell_col,
	input logic signed [47:0] cell_value,
	input logic signed [47:0] range_low,
	input logic signed [47:0] range_high
);
	a_low_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> range_low <= cell_value) else $error("range_low above cell value");
	a_high_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> range_high >= cell_value) else $error("range_high below cell value");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty && $stable(cell_value))
		else $error("waiting result changed");
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(cell_col)) else $error("cell column changed");
endmodule

bind grid_downsample_reducer_unit gdr_checker u_gdr_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .cell_col(cell_col),
	.cell_value(cell_value), .range_low(range_low), .range_high(range_high)
);

// ----- dv/grid_downsample_reducer_unit_tb.sv -----
// Self-checking testbench for grid_downsample_reducer_unit with a predictor of the reduced grid.
module grid_downsample_reducer_unit_tb;
	import gdr_pkg::*;

	typedef struct {
		logic [4:0]         col;
		logic [11:0]        row;
		logic signed [47:0] value;
		logic signed [47:0] low;
		logic signed [47:0] high;
		logic               last;
	} cell_t;

	localparam longint V48Max = 64'sh7FFF_FFFF_FFFF;
	localparam longint V48Min = -V48Max - 1;
	localparam int DrainCycles = 4000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [12:0]        cfg_data;
	logic               push;
	logic               full;
	logic [1:0]         opcode;
	logic signed [31:0] sample;
	logic               empty;
	logic               pop;
	logic [4:0]         cell_col;
	logic [11:0]        cell_row;
	logic signed [47:0] cell_value;
	logic signed [47:0] range_low;
	logic signed [47:0] range_high;
	logic               row_end;

	grid_downsample_reducer_unit dut (.*);

	cell_t  pending_cells[$];
	int     errors;
	int     requests_sent;
	int     cells_checked;
	int     frames_sent;
	logic   calm;

	// Predictor state and register copies.
	logic [12:0] m_src_w, m_src_h, m_red_h;
	logic [5:0]  m_red_w;
	mode_t       m_mode;
	longint      col_sum[RedW];
	int unsigned col_n[RedW];
	longint      band_sum[RedW];
	int unsigned band_n, pos_x, pos_y, band_row;
	longint      low_seen, high_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("grid_downsample_reducer_unit test failed");
		$finish;
	end

	function automatic longint sat48(longint v);
		if (v > V48Max) return V48Max;
		if (v < V48Min) return V48Min;
		return v;
	endfunction

	function automatic int unsigned fit_dim(int unsigned v, int unsigned hi);
		if (v == 0) return 1;
		return v > hi ? hi : v;
	endfunction

	function automatic void clear_grid();
		for (int i = 0; i < RedW; i++) begin
			col_sum[i] = 0;
			col_n[i] = 0;
			band_sum[i] = 0;
		end
		band_n = 0;
		pos_x = 0;
		pos_y = 0;
		band_row = 0;
	endfunction

	function automatic void clear_range();
		low_seen = V48Max;
		high_seen = 0;
	endfunction

	function automatic void reduce_request(logic [1:0] op, logic signed [31:0] smp);
		int unsigned sw, sh, rw, rh, ri, ry;
		longint s, v;
		bit band_done;
		cell_t c;
		if (op == OP_RESTART) begin
			clear_grid();
			return;
		end
		if (op == OP_NEWFRM) begin
			clear_grid();
			clear_range();
			return;
		end
		if (op != OP_SAMPLE) return;
		sw = fit_dim(m_src_w, SrcDim);
		sh = fit_dim(m_src_h, SrcDim);
		rw = fit_dim(m_red_w, RedW);
		rh = fit_dim(m_red_h, SrcDim);
		if (rw > sw) rw = sw;
		if (rh > sh) rh = sh;
		if (pos_y >= sh) return;
		s = smp;
		ri = (pos_x * rw) / sw;
		if (ri >= rw) ri = rw - 1;
		case (m_mode)
			MODE_AVG, MODE_SUM: col_sum[ri] = sat48(col_sum[ri] + s);
			MODE_MIN: if (col_n[ri] == 0 || s < col_sum[ri]) col_sum[ri] = s;
			default: if (col_n[ri] == 0 || s > col_sum[ri]) col_sum[ri] = s;
		endcase
		if (col_n[ri] < CntMax) col_n[ri]++;
		if (pos_x + 1 < sw) begin
			pos_x++;
			return;
		end
		ry = (pos_y * rh) / sh;
		if (band_n == 0) begin
			for (int i = 0; i < RedW; i++) band_sum[i] = 0;
			band_row = ry;
		end
		for (int i = 0; i < rw; i++) begin
			v = col_sum[i];
			if (m_mode == MODE_AVG && col_n[i] > 1) v = v / longint'(col_n[i]);
			band_sum[i] = sat48(band_sum[i] + v);
		end
		if (band_n < CntMax) band_n++;
		for (int i = 0; i < RedW; i++) begin
			col_sum[i] = 0;
			col_n[i] = 0;
		end
		band_done = (pos_y + 1 >= sh) || (((pos_y + 1) * rh) / sh != ry);
		pos_x = 0;
		pos_y++;
		if (!band_done) return;
		for (int i = 0; i < rw; i++) begin
			v = band_sum[i];
			if (band_n > 1) v = v / longint'(band_n);
			if (v < low_seen) low_seen = v;
			if (v > high_seen) high_seen = v;
			c.col = 5'(i);
			c.row = 12'(band_row);
			c.value = 48'(v);
			c.low = 48'(low_seen);
			c.high = 48'(high_seen);
			c.last = (i + 1 == rw);
			pending_cells.push_back(c);
		end
		band_n = 0;
	endfunction

	function automatic bit rest_now();
		return !calm && ($urandom_range(99) < 27);
	endfunction

	always @(negedge clk) begin
		if (!arst_n) pop <= 1'b0;
		else pop <= !rest_now();
	end

	always @(posedge clk) begin
		cell_t e;
		if (arst_n && pop && !empty) begin
			if (pending_cells.size() == 0) begin
				$error("unexpected cell col=%0d row=%0d value=%0d", cell_col, cell_row,
					cell_value);
				errors++;
			end else begin
				e = pending_cells.pop_front();
				cells_checked++;
				if (cell_col !== e.col) begin
					$error("cell_col expected %0d got %0d", e.col, cell_col);
					errors++;
				end
				if (cell_row !== e.row) begin
					$error("cell_row expected %0d got %0d", e.row, cell_row);
					errors++;
				end
				if (cell_value !== e.value) begin
					$error("cell_value expected %0d got %0d", e.value, cell_value);
					errors++;
				end
				if (range_low !== e.low) begin
					$error("range_low expected %0d got %0d", e.low, range_low);
					errors++;
				end
				if (range_high !== e.high) begin
					$error("range_high expected %0d got %0d", e.high, range_high);
					errors++;
				end
				if (row_end !== e.last) begin
					$error("row_end expected %0d got %0d", e.last, row_end);
					errors++;
				end
			end
		end
	end

	task automatic send_request(logic [1:0] op, logic signed [31:0] smp);
		@(negedge clk);
		while (rest_now()) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		sample <= smp;
		do @(posedge clk); while (full);
		reduce_request(op, smp);
		requests_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (pending_cells.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [12:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SRC_W: m_src_w = data;
			REG_SRC_H: m_src_h = data;
			REG_RED_W: m_red_w = data[5:0];
			REG_RED_H: m_red_h = data;
			default:   m_mode = mode_t'(data[1:0]);
		endcase
	endtask

	task automatic set_grid(logic [12:0] sw, logic [12:0] sh, logic [12:0] rw,
		logic [12:0] rh, mode_t mode);
		write_reg(REG_SRC_W, sw);
		write_reg(REG_SRC_H, sh);
		write_reg(REG_RED_W, rw);
		write_reg(REG_RED_H, rh);
		write_reg(REG_MODE, 13'(mode));
	endtask

	task automatic send_frame(int unsigned n);
		for (int i = 0; i < n; i++) send_request(OP_SAMPLE, $urandom);
		frames_sent++;
	endtask

	// Reset values give a one-by-one grid; extra samples fall beyond the frame.
	task automatic test_reset_defaults();
		send_request(OP_SAMPLE, 32'sh7FFF_FFFF);
		send_request(OP_SAMPLE, 32'sh1234_5678);
		send_request(OP_NONE, 32'sh0);
		send_request(OP_RESTART, 32'sh0);
		send_request(OP_SAMPLE, 32'sh8000_0000);
		send_request(OP_NEWFRM, $urandom);
		send_request(OP_SAMPLE, -32'sh1);
		wait_idle();
	endtask

	task automatic test_combine_modes();
		for (int m = 0; m < 4; m++) begin
			set_grid(4, 2, 2, 1, mode_t'(m));
			send_request(OP_NEWFRM, 32'sh0);
			send_request(OP_SAMPLE, 32'sh7FFF_FFFF);
			send_request(OP_SAMPLE, 32'sh8000_0000);
			send_request(OP_SAMPLE, 32'sh0001_0000);
			send_request(OP_SAMPLE, -32'sh3);
			send_frame(4);
			wait_idle();
		end
	endtask

	// Zero sizes act as one, oversized ones are clamped.
	task automatic test_size_limits();
		set_grid(0, 0, 0, 0, MODE_AVG);
		send_request(OP_NEWFRM, 32'sh0);
		send_request(OP_SAMPLE, -32'sh7);
		wait_idle();
		set_grid(40, 3, 63, 8191, MODE_MAX);
		send_request(OP_RESTART, 32'sh0);
		calm = 1'b1;
		send_frame(40);
		wait_idle();
		calm = 1'b0;
		set_grid(8191, 1, 1, 4096, MODE_SUM);
		send_request(OP_NEWFRM, 32'sh0);
		send_frame(16);
		wait_idle();
	endtask

	task automatic test_random_frames();
		int unsigned sent, sw, sh, op_roll;
		sent = 0;
		while (sent < 90) begin
			sw = ($urandom_range(9) == 0) ? $urandom_range(33, 48) : $urandom_range(1, 12);
			sh = (sw > 12) ? $urandom_range(1, 2) : $urandom_range(1, 6);
			set_grid(13'(sw), 13'(sh), 13'($urandom_range(0, 63)),
				($urandom_range(5) == 0) ? 13'd4096 : 13'($urandom_range(0, 8)),
				mode_t'($urandom_range(3)));
			calm = ($urandom_range(3) == 0);
			send_request($urandom_range(1) ? OP_NEWFRM : OP_RESTART, $urandom);
			for (int i = 0; i < sw * sh + $urandom_range(2); i++) begin
				op_roll = $urandom_range(99);
				if (op_roll < 4) send_request(OP_NONE, $urandom);
				else if (op_roll < 6) send_request(2'($urandom_range(1, 2)), $urandom);
				else begin
					send_request(OP_SAMPLE, $urandom);
					sent++;
				end
			end
			frames_sent++;
			calm = 1'b0;
			wait_idle();
		end
	endtask

	initial begin
		errors = 0;
		requests_sent = 0;
		cells_checked = 0;
		frames_sent = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SRC_W;
		cfg_data = '0;
		push = 1'b0;
		opcode = OP_NONE;
		sample = '0;
		m_src_w = 1;
		m_src_h = 1;
		m_red_w = 32;
		m_red_h = 32;
		m_mode = MODE_AVG;
		clear_grid();
		clear_range();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_combine_modes();
		test_size_limits();
		test_random_frames();
		wait_idle();
		$display("Sent %0d requests over %0d frames in all four combine modes.",
			requests_sent, frames_sent);
		$display("Checked %0d reduced cells; %0d mismatches.", cells_checked, errors);
		if (errors == 0 && pending_cells.size() == 0) begin
			$display("grid_downsample_reducer_unit test passed");
		end else begin
			$display("grid_downsample_reducer_unit test failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/gdr_pkg.sv
rtl/gdr_divider.sv
rtl/gdr_front.sv
rtl/gdr_queue.sv
rtl/gdr_back.sv
rtl/grid_downsample_reducer_unit.sv
rtl/gdr_checker.sv
dv/grid_downsample_reducer_unit_tb.sv
